/* hdl/scaled_glyph_blitter_macros.svh */
// assertion macros for the scaled glyph blitter
`ifndef SCALED_GLYPH_BLITTER_MACROS_SVH
`define SCALED_GLYPH_BLITTER_MACROS_SVH

// same-cycle implication
`define SGB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SGB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/sgb_pkg.sv */
// shared types, constants and helper functions of the scaled glyph blitter
`default_nettype none

package sgb_pkg;

    localparam int unsigned MAX_SCALE       = 8;
    localparam int unsigned MAX_GLYPH_WIDTH = 64;

    localparam logic [31:0] TRANSPARENT_COLOR = 32'hFF00_0000;

    localparam logic [1:0] ERR_OK      = 2'd0;
    localparam logic [1:0] ERR_SIZE    = 2'd1;
    localparam logic [1:0] ERR_ORIGIN  = 2'd2;
    localparam logic [1:0] ERR_OVERRUN = 2'd3;

    typedef enum logic [2:0] {
        REG_LINE_PITCH      = 3'd0,
        REG_HORIZONTAL_SIZE = 3'd1,
        REG_VERTICAL_SIZE   = 3'd2,
        REG_GLYPH_WIDTH     = 3'd3,
        REG_GLYPH_HEIGHT    = 3'd4,
        REG_SCALE_FACTOR    = 3'd5,
        REG_INK_COLOR       = 3'd6,
        REG_PAPER_COLOR     = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic [13:0] line_pitch;
        logic [13:0] horizontal_size;
        logic [13:0] vertical_size;
        logic [6:0]  glyph_width;
        logic [6:0]  glyph_height;
        logic [3:0]  scale_factor;
        logic [31:0] ink_color;
        logic [31:0] paper_color;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic calc_origin;
        logic calc_row;
        logic calc_index;
        logic calc_final;
        logic draw;
    } ctrl_cmd_t;

    typedef struct packed {
        logic draw_done;
    } ctrl_status_t;

    function automatic logic [3:0] eff_scale(input logic [3:0] scale);
        eff_scale = (scale > 4'(MAX_SCALE)) ? 4'(MAX_SCALE) : scale;
    endfunction

    function automatic logic [6:0] eff_width(input logic [6:0] width);
        eff_width = (width > 7'(MAX_GLYPH_WIDTH)) ? 7'(MAX_GLYPH_WIDTH) : width;
    endfunction

endpackage

`default_nettype wire

/* hdl/scaled_glyph_blitter.sv */
// top level of the scaled glyph blitter
// Takes one glyph byte per start pulse while busy is low and draws it as horizontal
// spans, one span per cycle on the result ports while a drawn column is output, with
// result_valid high for that one cycle; the receiver cannot stall, so results must be
// taken as they come. After a byte is accepted, busy stays high through four address
// setup steps (origin, row, index, final; one accumulator add each, the wide products
// spread over the first three), then while spans are drawn and skipped columns are
// passed up to the last drawn column, plus a closing step. Each span is registered and
// leaves the output register in the cycle after it is formed. Configuration writes are
// always ready and must only be issued while busy is low and no span is still due.
`default_nettype none
`include "scaled_glyph_blitter_macros.svh"

module scaled_glyph_blitter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [7:0]  glyph_bits,
    input  wire logic [5:0]  glyph_row,
    input  wire logic [2:0]  byte_in_row,
    input  wire logic [12:0] origin_x,
    input  wire logic [12:0] origin_y,
    input  wire logic [9:0]  char_index,
    output logic             result_valid,
    output logic [31:0]      pixel_offset,
    output logic [3:0]       span_length,
    output logic [31:0]      span_color,
    output logic [1:0]       bounds_error,
    output logic             last_span
);

    sgb_pkg::cfg_t         cfg;
    sgb_pkg::ctrl_cmd_t    cmd;
    sgb_pkg::ctrl_status_t status;

    sgb_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sgb_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    sgb_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .status       (status),
        .glyph_bits   (glyph_bits),
        .glyph_row    (glyph_row),
        .byte_in_row  (byte_in_row),
        .origin_x     (origin_x),
        .origin_y     (origin_y),
        .char_index   (char_index),
        .result_valid (result_valid),
        .pixel_offset (pixel_offset),
        .span_length  (span_length),
        .span_color   (span_color),
        .bounds_error (bounds_error),
        .last_span    (last_span)
    );

    `SGB_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted byte not busy")
    `SGB_ASSERT_NOW(a_span_while_drawing, clk, rst_n, result_valid, $past(busy), "span while idle")
    `SGB_ASSERT_NOW(a_last_with_beat, clk, rst_n, last_span, result_valid, "last_span without beat")
    `SGB_ASSERT_NOW(a_span_nonzero, clk, rst_n, result_valid, span_length != 4'd0, "empty span")

endmodule

`default_nettype wire

/* hdl/sgb_cfg_regs.sv */
// configuration register file with its write channel
`default_nettype none

module sgb_cfg_regs (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [31:0]   cfg_data,
    output sgb_pkg::cfg_t      cfg
);

    sgb_pkg::cfg_t cfg_reg;
    sgb_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (sgb_pkg::reg_index_t'(cfg_index))
                sgb_pkg::REG_LINE_PITCH:      cfg_next.line_pitch      = cfg_data[13:0];
                sgb_pkg::REG_HORIZONTAL_SIZE: cfg_next.horizontal_size = cfg_data[13:0];
                sgb_pkg::REG_VERTICAL_SIZE:   cfg_next.vertical_size   = cfg_data[13:0];
                sgb_pkg::REG_GLYPH_WIDTH:     cfg_next.glyph_width     = cfg_data[6:0];
                sgb_pkg::REG_GLYPH_HEIGHT:    cfg_next.glyph_height    = cfg_data[6:0];
                sgb_pkg::REG_SCALE_FACTOR:    cfg_next.scale_factor    = cfg_data[3:0];
                sgb_pkg::REG_INK_COLOR:       cfg_next.ink_color       = cfg_data;
                sgb_pkg::REG_PAPER_COLOR:     cfg_next.paper_color     = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_pitch      <= 14'd1024;
            cfg_reg.horizontal_size <= 14'd1024;
            cfg_reg.vertical_size   <= 14'd768;
            cfg_reg.glyph_width     <= 7'd8;
            cfg_reg.glyph_height    <= 7'd8;
            cfg_reg.scale_factor    <= 4'd1;
            cfg_reg.ink_color       <= 32'h00FF_FFFF;
            cfg_reg.paper_color     <= 32'h0000_0000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/sgb_ctrl.sv */
// controller state machine: address setup steps and span drawing
`default_nettype none

module sgb_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire sgb_pkg::ctrl_status_t status,
    output sgb_pkg::ctrl_cmd_t        cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_ORIGIN = 6'b000010,
        ST_ROW    = 6'b000100,
        ST_INDEX  = 6'b001000,
        ST_FINAL  = 6'b010000,
        ST_DRAW   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_ORIGIN;
                end
            end
            ST_ORIGIN:
            begin
                cmd.calc_origin = 1'b1;
                state_next      = ST_ROW;
            end
            ST_ROW:
            begin
                cmd.calc_row = 1'b1;
                state_next   = ST_INDEX;
            end
            ST_INDEX:
            begin
                cmd.calc_index = 1'b1;
                state_next     = ST_FINAL;
            end
            ST_FINAL:
            begin
                cmd.calc_final = 1'b1;
                state_next     = ST_DRAW;
            end
            ST_DRAW:
            begin
                cmd.draw = 1'b1;
                if (status.draw_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/sgb_datapath.sv */
// datapath: item latch, span address arithmetic, bounds check and result register
`default_nettype none

module sgb_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire sgb_pkg::cfg_t        cfg,
    input  wire sgb_pkg::ctrl_cmd_t   cmd,
    output sgb_pkg::ctrl_status_t     status,
    input  wire logic [7:0]           glyph_bits,
    input  wire logic [5:0]           glyph_row,
    input  wire logic [2:0]           byte_in_row,
    input  wire logic [12:0]          origin_x,
    input  wire logic [12:0]          origin_y,
    input  wire logic [9:0]           char_index,
    output logic                      result_valid,
    output logic [31:0]               pixel_offset,
    output logic [3:0]                span_length,
    output logic [31:0]               span_color,
    output logic [1:0]                bounds_error,
    output logic                      last_span
);

    logic [3:0] s;
    logic [6:0] w;

    logic [5:0]  row_reg,  row_next;
    logic [2:0]  k_reg,    k_next;
    logic [12:0] ox_reg,   ox_next;
    logic [12:0] oy_reg,   oy_next;
    logic [9:0]  idx_reg,  idx_next;
    logic [7:0]  set_reg,  set_next;
    logic [7:0]  mask_reg, mask_next;

    logic [26:0] mul_reg,  mul_next;
    logic [31:0] acc_reg,  acc_next;
    logic [31:0] cur_reg,  cur_next;
    logic [10:0] sh_reg,   sh_next;
    logic [10:0] sw_reg,   sw_next;
    logic [9:0]  rs_reg,   rs_next;
    logic [13:0] si_reg,   si_next;
    logic [1:0]  err_reg,  err_next;
    logic [2:0]  line_reg, line_next;

    logic        result_valid_reg, result_valid_next;
    logic        last_span_reg,    last_span_next;
    logic [31:0] pixel_offset_reg, pixel_offset_next;
    logic [3:0]  span_length_reg,  span_length_next;
    logic [31:0] span_color_reg,   span_color_next;
    logic [1:0]  bounds_error_reg, bounds_error_next;

    logic [7:0]  load_mask;
    logic        item_ok;
    logic [6:0]  sk;
    logic [14:0] hs15;
    logic [14:0] vs15;
    logic        line_last;

    assign s = sgb_pkg::eff_scale(cfg.scale_factor);
    assign w = sgb_pkg::eff_width(cfg.glyph_width);

    assign item_ok = (s != 4'd0) && (w != 7'd0) && ({1'b0, glyph_row} < cfg.glyph_height);

    // columns that produce spans
    always_comb
    begin
        for (int b = 0; b < 8; b++)
        begin
            load_mask[b] = item_ok
                && ({1'b0, byte_in_row, 3'(b)} < w)
                && (glyph_bits[b] || (cfg.paper_color != sgb_pkg::TRANSPARENT_COLOR));
        end
    end

    assign sk        = 7'(s) * 7'(k_reg);
    assign hs15      = 15'(cfg.horizontal_size);
    assign vs15      = 15'(cfg.vertical_size);
    assign line_last = ({1'b0, line_reg} == (s - 4'd1));

    assign status.draw_done = (mask_reg == 8'd0);

    always_comb
    begin
        row_next  = row_reg;
        k_next    = k_reg;
        ox_next   = ox_reg;
        oy_next   = oy_reg;
        idx_next  = idx_reg;
        set_next  = set_reg;
        mask_next = mask_reg;
        mul_next  = mul_reg;
        acc_next  = acc_reg;
        cur_next  = cur_reg;
        sh_next   = sh_reg;
        sw_next   = sw_reg;
        rs_next   = rs_reg;
        si_next   = si_reg;
        err_next  = err_reg;
        line_next = line_reg;

        result_valid_next = 1'b0;
        last_span_next    = 1'b0;
        pixel_offset_next = pixel_offset_reg;
        span_length_next  = span_length_reg;
        span_color_next   = span_color_reg;
        bounds_error_next = bounds_error_reg;

        if (cmd.load)
        begin
            row_next  = glyph_row;
            k_next    = byte_in_row;
            ox_next   = origin_x;
            oy_next   = origin_y;
            idx_next  = char_index;
            set_next  = glyph_bits;
            mask_next = load_mask;
        end

        // oy*p, small products and origin column term
        if (cmd.calc_origin)
        begin
            mul_next = 27'(oy_reg) * 27'(cfg.line_pitch);
            acc_next = 32'(ox_reg) + 32'({sk, 3'b000});
            sh_next  = 11'(s) * 11'(cfg.glyph_height);
            sw_next  = 11'(s) * 11'(w);
            rs_next  = 10'(row_reg) * 10'(s);
            si_next  = 14'(idx_reg) * 14'(s);
        end

        if (cmd.calc_row)
        begin
            mul_next = 27'(rs_reg) * 27'(cfg.line_pitch);
            acc_next = acc_reg + 32'(mul_reg);
            if ((15'(cfg.glyph_height) > vs15) || (15'(w) > hs15))
            begin
                err_next = sgb_pkg::ERR_SIZE;
            end
            else if ((15'(ox_reg) > hs15) || (15'(oy_reg) > vs15))
            begin
                err_next = sgb_pkg::ERR_ORIGIN;
            end
            else if (((15'(oy_reg) + 15'(sh_reg)) > vs15)
                || ((15'(ox_reg) + 15'(sw_reg)) > hs15))
            begin
                err_next = sgb_pkg::ERR_OVERRUN;
            end
            else
            begin
                err_next = sgb_pkg::ERR_OK;
            end
        end

        if (cmd.calc_index)
        begin
            mul_next = 27'(si_reg) * 27'(w);
            acc_next = acc_reg + 32'(mul_reg);
        end

        if (cmd.calc_final)
        begin
            acc_next  = acc_reg + 32'(mul_reg);
            cur_next  = acc_reg + 32'(mul_reg);
            line_next = 3'd0;
        end

        if (cmd.draw && (mask_reg != 8'd0))
        begin
            if (mask_reg[0])
            begin
                result_valid_next = 1'b1;
                last_span_next    = line_last && (mask_reg[7:1] == 7'd0);
                pixel_offset_next = cur_reg;
                span_length_next  = s;
                span_color_next   = set_reg[0] ? cfg.ink_color : cfg.paper_color;
                bounds_error_next = err_reg;
            end
            if (!mask_reg[0] || line_last)
            begin
                // next column
                mask_next = {1'b0, mask_reg[7:1]};
                set_next  = {1'b0, set_reg[7:1]};
                acc_next  = acc_reg + 32'(s);
                cur_next  = acc_reg + 32'(s);
                line_next = 3'd0;
            end
            else
            begin
                cur_next  = cur_reg + 32'(cfg.line_pitch);
                line_next = line_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg         <= 8'd0;
            result_valid_reg <= 1'b0;
            last_span_reg    <= 1'b0;
            line_reg         <= 3'd0;
        end
        else
        begin
            mask_reg         <= mask_next;
            result_valid_reg <= result_valid_next;
            last_span_reg    <= last_span_next;
            line_reg         <= line_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg          <= row_next;
        k_reg            <= k_next;
        ox_reg           <= ox_next;
        oy_reg           <= oy_next;
        idx_reg          <= idx_next;
        set_reg          <= set_next;
        mul_reg          <= mul_next;
        acc_reg          <= acc_next;
        cur_reg          <= cur_next;
        sh_reg           <= sh_next;
        sw_reg           <= sw_next;
        rs_reg           <= rs_next;
        si_reg           <= si_next;
        err_reg          <= err_next;
        pixel_offset_reg <= pixel_offset_next;
        span_length_reg  <= span_length_next;
        span_color_reg   <= span_color_next;
        bounds_error_reg <= bounds_error_next;
    end

    assign result_valid = result_valid_reg;
    assign last_span    = last_span_reg;
    assign pixel_offset = pixel_offset_reg;
    assign span_length  = span_length_reg;
    assign span_color   = span_color_reg;
    assign bounds_error = bounds_error_reg;

endmodule

`default_nettype wire
